// ===== rtl/efvr_pkg.sv =====
// Shared constants and arithmetic helpers for the Euler-frame vector rotation core.
package efvr_pkg;

	localparam int CordicStages = 30;
	localparam int CordicW      = 34;
	localparam int CoefW        = 32;
	localparam int VecW         = 32;
	localparam int ProdW        = 64;
	localparam int AccW         = 66;
	// CORDIC stages, final flip, two product stages, combine, vector multiply, output.
	localparam int PipeDepth    = CordicStages + 6;

	localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;
	localparam logic signed [CordicW-1:0] UnitPos    = 34'sd1073741824;
	localparam logic signed [CordicW-1:0] UnitNeg    = -34'sd1073741824;
	localparam logic                      CmdToGround = 1'b0;

	// Arctangent of two to the minus i, in 2^32-per-turn units.
	function automatic logic signed [CordicW-1:0] atan_val(input int i);
		logic signed [CordicW-1:0] r;
		begin
			case (i)
				0: r = 34'sd536870912;   1: r = 34'sd316933406;   2: r = 34'sd167458907;
				3: r = 34'sd85004756;    4: r = 34'sd42667331;    5: r = 34'sd21354465;
				6: r = 34'sd10679838;    7: r = 34'sd5340245;     8: r = 34'sd2670163;
				9: r = 34'sd1335087;     10: r = 34'sd667544;     11: r = 34'sd333772;
				12: r = 34'sd166886;     13: r = 34'sd83443;      14: r = 34'sd41722;
				15: r = 34'sd20861;      16: r = 34'sd10430;      17: r = 34'sd5215;
				18: r = 34'sd2608;       19: r = 34'sd1304;       20: r = 34'sd652;
				21: r = 34'sd326;        22: r = 34'sd163;        23: r = 34'sd81;
				24: r = 34'sd41;         25: r = 34'sd20;         26: r = 34'sd10;
				27: r = 34'sd5;          28: r = 34'sd3;          29: r = 34'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// Clamp a value to the closed unit range of Q1.30.
	function automatic logic signed [CoefW-1:0] clamp_unit(input logic signed [CordicW-1:0] v);
		logic signed [CordicW-1:0] r;
		begin
			r = v;
			if (v > UnitPos) r = UnitPos;
			if (v < UnitNeg) r = UnitNeg;
			return r[CoefW-1:0];
		end
	endfunction

	// Q1.30 product rounded half up; operands stay within the unit range.
	function automatic logic signed [CoefW-1:0] qmul(input logic signed [CoefW-1:0] a,
			input logic signed [CoefW-1:0] b);
		logic signed [ProdW-1:0] p;
		begin
			p = ProdW'(a) * ProdW'(b) + 64'sd536870912;
			return p[61:30];
		end
	endfunction

endpackage

// ===== rtl/euler_frame_vector_rotation_core.sv =====
// Euler ZYX vector rotation core: CORDIC sines and cosines, matrix build, matrix-vector product.
//
//  channel | signals                                              | direction
//  input   | in_valid, in_ready, command, vec_x/y/z, roll/pitch/yaw_angle | in
//  output  | out_valid, out_ready, out_x, out_y, out_z            | out
//
// One word enters per cycle while the pipeline advances; it holds the 30 CORDIC stages plus
// six stages of matrix and dot-product arithmetic.
// Reset clears only the stage valid bits; data registers are not reset.
// When the output word is held and not taken, the whole pipeline freezes, so nothing
// is dropped or repeated, and in_ready falls in the same cycle.
module euler_frame_vector_rotation_core
	import efvr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    command,
	input  logic signed [VecW-1:0]  vec_x,
	input  logic signed [VecW-1:0]  vec_y,
	input  logic signed [VecW-1:0]  vec_z,
	input  logic [15:0]             roll_angle,
	input  logic [15:0]             pitch_angle,
	input  logic [15:0]             yaw_angle,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VecW-1:0]  out_x,
	output logic signed [VecW-1:0]  out_y,
	output logic signed [VecW-1:0]  out_z
);

	localparam int FlipSt = CordicStages;

	typedef struct packed {
		logic                   cmd;
		logic signed [VecW-1:0] vx;
		logic signed [VecW-1:0] vy;
		logic signed [VecW-1:0] vz;
	} side_t;

	logic                   en;
	logic [PipeDepth-1:0]   vld_q;

	// Angle pre-reduction into the right half plane.
	logic [2:0]                  flip_in;
	logic signed [CordicW-1:0]   z_in [3];
	logic [15:0]                 ang_in [3];

	// CORDIC pipeline, one register stage per iteration.
	logic signed [CordicW-1:0] cx_s [3][CordicStages];
	logic signed [CordicW-1:0] cy_s [3][CordicStages];
	logic signed [CordicW-1:0] cz_s [3][CordicStages];
	logic [2:0]                fl_s [CordicStages];
	side_t                     sd_s [CordicStages];

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[PipeDepth-1];

	assign ang_in[0] = roll_angle;
	assign ang_in[1] = pitch_angle;
	assign ang_in[2] = yaw_angle;

	// Angles in the left half plane are turned by half a turn and negated after.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			flip_in[k] = (ang_in[k] > 16'h4000) && (ang_in[k] < 16'hC000);
			z_in[k]    = CordicW'($signed({ang_in[k] ^ {flip_in[k], 15'd0}, 16'd0}));
		end
	end

	// Valid bits move with the data whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PipeDepth-2:0], in_valid};
		end
	end

	for (genvar g = 0; g < CordicStages; g++) begin : g_cordic
		logic signed [CordicW-1:0] px [3];
		logic signed [CordicW-1:0] py [3];
		logic signed [CordicW-1:0] pz [3];
		logic [2:0]                pf;
		side_t                     ps;

		// Stage source: the port inputs for the first iteration, else the previous stage.
		always_comb begin
			for (int k = 0; k < 3; k++) begin
				if (g == 0) begin
					px[k] = CordicGain;
					py[k] = '0;
					pz[k] = z_in[k];
				end else begin
					px[k] = cx_s[k][(g == 0) ? 0 : g-1];
					py[k] = cy_s[k][(g == 0) ? 0 : g-1];
					pz[k] = cz_s[k][(g == 0) ? 0 : g-1];
				end
			end
			if (g == 0) begin
				pf = flip_in;
				ps = '{cmd: command, vx: vec_x, vy: vec_y, vz: vec_z};
			end else begin
				pf = fl_s[(g == 0) ? 0 : g-1];
				ps = sd_s[(g == 0) ? 0 : g-1];
			end
		end

		// One micro-rotation for each of the three angles.
		for (genvar k = 0; k < 3; k++) begin : g_axis
			always_ff @(posedge clk) begin
				if (en) begin
					if (!pz[k][CordicW-1]) begin
						cx_s[k][g] <= px[k] - (py[k] >>> g);
						cy_s[k][g] <= py[k] + (px[k] >>> g);
						cz_s[k][g] <= pz[k] - atan_val(g);
					end else begin
						cx_s[k][g] <= px[k] + (py[k] >>> g);
						cy_s[k][g] <= py[k] - (px[k] >>> g);
						cz_s[k][g] <= pz[k] + atan_val(g);
					end
				end
			end
		end

		// The flip marks and the side data ride along with the rotation.
		always_ff @(posedge clk) begin
			if (en) begin
				fl_s[g] <= pf;
				sd_s[g] <= ps;
			end
		end
	end

	// Undo the half-turn reduction and clamp to the unit range.
	logic signed [CoefW-1:0] sin_s31 [3];
	logic signed [CoefW-1:0] cos_s31 [3];
	side_t                   sd_s31;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (fl_s[FlipSt-1][k]) begin
					cos_s31[k] <= clamp_unit(-cx_s[k][FlipSt-1]);
					sin_s31[k] <= clamp_unit(-cy_s[k][FlipSt-1]);
				end else begin
					cos_s31[k] <= clamp_unit(cx_s[k][FlipSt-1]);
					sin_s31[k] <= clamp_unit(cy_s[k][FlipSt-1]);
				end
			end
			sd_s31 <= sd_s[FlipSt-1];
		end
	end

	// First product stage: the pairwise products of sines and cosines that the matrix needs.
	logic signed [CoefW-1:0] sfst_s32, cfst_s32, ctcp_s32, cfsp_s32, sfsp_s32, ctsp_s32;
	logic signed [CoefW-1:0] cfcp_s32, sfcp_s32, sfct_s32, cfct_s32, st_s32, cp_s32, sp_s32;
	side_t                   sd_s32;

	always_ff @(posedge clk) begin
		if (en) begin
			sfst_s32 <= qmul(sin_s31[0], sin_s31[1]);
			cfst_s32 <= qmul(cos_s31[0], sin_s31[1]);
			ctcp_s32 <= qmul(cos_s31[1], cos_s31[2]);
			cfsp_s32 <= qmul(cos_s31[0], sin_s31[2]);
			sfsp_s32 <= qmul(sin_s31[0], sin_s31[2]);
			ctsp_s32 <= qmul(cos_s31[1], sin_s31[2]);
			cfcp_s32 <= qmul(cos_s31[0], cos_s31[2]);
			sfcp_s32 <= qmul(sin_s31[0], cos_s31[2]);
			sfct_s32 <= qmul(sin_s31[0], cos_s31[1]);
			cfct_s32 <= qmul(cos_s31[0], cos_s31[1]);
			st_s32   <= sin_s31[1];
			cp_s32   <= cos_s31[2];
			sp_s32   <= sin_s31[2];
			sd_s32   <= sd_s31;
		end
	end

	// Second product stage: the triple products that hold the pitch sine, for the first two rows.
	logic signed [CoefW-1:0] a01_s33, a02_s33, a11_s33, a12_s33;
	logic signed [CoefW-1:0] cfsp_s33, sfsp_s33, cfcp_s33, sfcp_s33;
	logic signed [CoefW-1:0] ctcp_s33, ctsp_s33, sfct_s33, cfct_s33, st_s33;
	side_t                   sd_s33;

	always_ff @(posedge clk) begin
		if (en) begin
			a01_s33  <= qmul(sfst_s32, cp_s32);
			a02_s33  <= qmul(cfst_s32, cp_s32);
			a11_s33  <= qmul(sfst_s32, sp_s32);
			a12_s33  <= qmul(cfst_s32, sp_s32);
			cfsp_s33 <= cfsp_s32;
			sfsp_s33 <= sfsp_s32;
			cfcp_s33 <= cfcp_s32;
			sfcp_s33 <= sfcp_s32;
			ctcp_s33 <= ctcp_s32;
			ctsp_s33 <= ctsp_s32;
			sfct_s33 <= sfct_s32;
			cfct_s33 <= cfct_s32;
			st_s33   <= st_s32;
			sd_s33   <= sd_s32;
		end
	end

	// Combine into the nine clamped matrix terms, row major.
	logic signed [CoefW-1:0] m_s34 [9];
	side_t                   sd_s34;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s34[0] <= clamp_unit(CordicW'(ctcp_s33));
			m_s34[1] <= clamp_unit(CordicW'(a01_s33) - CordicW'(cfsp_s33));
			m_s34[2] <= clamp_unit(CordicW'(a02_s33) + CordicW'(sfsp_s33));
			m_s34[3] <= clamp_unit(CordicW'(ctsp_s33));
			m_s34[4] <= clamp_unit(CordicW'(a11_s33) + CordicW'(cfcp_s33));
			m_s34[5] <= clamp_unit(CordicW'(a12_s33) - CordicW'(sfcp_s33));
			m_s34[6] <= clamp_unit(-CordicW'(st_s33));
			m_s34[7] <= clamp_unit(CordicW'(sfct_s33));
			m_s34[8] <= clamp_unit(CordicW'(cfct_s33));
			sd_s34   <= sd_s33;
		end
	end

	// Multiply the matrix or its transpose by the vector, term by term.
	logic signed [ProdW-1:0] p_s35 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					logic signed [CoefW-1:0] coef;
					logic signed [VecW-1:0]  vc;
					coef = (sd_s34.cmd == CmdToGround) ? m_s34[r*3+c] : m_s34[c*3+r];
					vc   = (c == 0) ? sd_s34.vx : ((c == 1) ? sd_s34.vy : sd_s34.vz);
					p_s35[r][c] <= ProdW'(coef) * ProdW'(vc);
				end
			end
		end
	end

	// Sum each row, round half up and saturate to Q15.16.
	logic signed [VecW-1:0] res_s36 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				logic signed [AccW-1:0] acc;
				logic signed [AccW-1:0] sh;
				acc = AccW'(p_s35[r][0]) + AccW'(p_s35[r][1]) + AccW'(p_s35[r][2])
					+ 66'sd536870912;
				sh  = acc >>> 30;
				if (sh > 66'sd2147483647)
					res_s36[r] <= 32'sh7FFFFFFF;
				else if (sh < -66'sd2147483648)
					res_s36[r] <= 32'sh80000000;
				else
					res_s36[r] <= sh[VecW-1:0];
			end
		end
	end

	assign out_x = res_s36[0];
	assign out_y = res_s36[1];
	assign out_z = res_s36[2];

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the Euler ZYX vector rotation core.
module tb
	import efvr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandWords = 2000;
	localparam int Latency = PipeDepth;

	// Rotation directions, named after the two frames.
	typedef enum logic {
		BodyToGround = 1'b0,
		GroundToBody = 1'b1
	} rot_dir_e;

	typedef struct {
		logic cmd;
		logic signed [31:0] x, y, z;
		logic [15:0] roll, pitch, yaw;
	} rot_word_t;

	typedef struct {
		logic signed [31:0] x, y, z;
	} rot_result_t;

	// One directed row: the word, and an optional hand-written result.
	typedef struct {
		rot_word_t w;
		bit known;
		rot_result_t r;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic command;
	logic signed [31:0] vec_x, vec_y, vec_z;
	logic [15:0] roll_angle, pitch_angle, yaw_angle;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] out_x, out_y, out_z;

	rot_result_t rotated_q[$];
	int errors;
	bit calm;
	bit drain_done;

	euler_frame_vector_rotation_core uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Arithmetic shift right on 64-bit values (floors toward minus infinity).
	function automatic longint sra64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unit_clip(longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return sra64(a * b + 64'sd536870912, 30);
	endfunction

	// CORDIC sine and cosine of a 16-bit binary angle, Q1.30.
	function automatic void angle_sincos(logic [15:0] ang, output longint s,
			output longint c);
		longint tab[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
			20, 10, 5, 3, 1};
		logic [31:0] a;
		bit flip;
		longint z, x, y, nx, ny;
		a = {ang, 16'h0};
		flip = 1'b0;
		x = 652032874;
		y = 0;
		if (a > 32'h4000_0000 && a < 32'hC000_0000) begin
			a = a - 32'h8000_0000;
			flip = 1'b1;
		end
		z = longint'($signed(a));
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - sra64(y, i);
				ny = y + sra64(x, i);
				z -= tab[i];
			end else begin
				nx = x + sra64(y, i);
				ny = y - sra64(x, i);
				z += tab[i];
			end
			x = nx;
			y = ny;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = unit_clip(x);
		s = unit_clip(y);
	endfunction

	function automatic logic signed [31:0] dot_sat(longint m0, longint m1, longint m2,
			longint v0, longint v1, longint v2);
		longint r;
		r = sra64(m0 * v0 + m1 * v1 + m2 * v2 + 64'sd536870912, 30);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	// Expected rotation of one word.
	function automatic rot_result_t rotate_vector(rot_word_t w);
		longint sf, cf, st, ct, sp, cp, sfst, cfst, vx, vy, vz;
		longint m[3][3];
		rot_result_t r;
		angle_sincos(w.roll, sf, cf);
		angle_sincos(w.pitch, st, ct);
		angle_sincos(w.yaw, sp, cp);
		vx = w.x;
		vy = w.y;
		vz = w.z;
		sfst = q30_mul(sf, st);
		cfst = q30_mul(cf, st);
		m[0][0] = unit_clip(q30_mul(ct, cp));
		m[0][1] = unit_clip(q30_mul(sfst, cp) - q30_mul(cf, sp));
		m[0][2] = unit_clip(q30_mul(cfst, cp) + q30_mul(sf, sp));
		m[1][0] = unit_clip(q30_mul(ct, sp));
		m[1][1] = unit_clip(q30_mul(sfst, sp) + q30_mul(cf, cp));
		m[1][2] = unit_clip(q30_mul(cfst, sp) - q30_mul(sf, cp));
		m[2][0] = unit_clip(-st);
		m[2][1] = unit_clip(q30_mul(sf, ct));
		m[2][2] = unit_clip(q30_mul(cf, ct));
		if (w.cmd == BodyToGround) begin
			r.x = dot_sat(m[0][0], m[0][1], m[0][2], vx, vy, vz);
			r.y = dot_sat(m[1][0], m[1][1], m[1][2], vx, vy, vz);
			r.z = dot_sat(m[2][0], m[2][1], m[2][2], vx, vy, vz);
		end else begin
			r.x = dot_sat(m[0][0], m[1][0], m[2][0], vx, vy, vz);
			r.y = dot_sat(m[0][1], m[1][1], m[2][1], vx, vy, vz);
			r.z = dot_sat(m[0][2], m[1][2], m[2][2], vx, vy, vz);
		end
		return r;
	endfunction

	function automatic rot_word_t mk(logic c, int x, int y, int z, logic [15:0] f,
			logic [15:0] t, logic [15:0] p);
		rot_word_t w;
		w.cmd = c; w.x = x; w.y = y; w.z = z;
		w.roll = f; w.pitch = t; w.yaw = p;
		return w;
	endfunction

	function automatic dir_row_t row(rot_word_t w, bit known = 0, int ex = 0,
			int ey = 0, int ez = 0);
		dir_row_t d;
		d.w = w; d.known = known;
		d.r.x = ex; d.r.y = ey; d.r.z = ez;
		return d;
	endfunction

	function automatic rot_word_t rand_word();
		rot_word_t w;
		w.cmd = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0: begin
				w.x = $urandom; w.y = $urandom; w.z = $urandom;
			end
			1: begin
				w.x = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
				w.y = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
				w.z = $urandom;
			end
			default: begin
				w.x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
				w.y = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
				w.z = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			end
		endcase
		// Quarter-turn multiples hit the reduction boundaries.
		w.roll = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3) << 14) : 16'($urandom);
		w.pitch = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3) << 14) : 16'($urandom);
		w.yaw = 16'($urandom);
		return w;
	endfunction

	// Drive one word and hold it until accepted; valid drops only while idling.
	task automatic send_word(rot_word_t w, bit known, rot_result_t r);
		while (!calm && $urandom_range(0, 99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= w.cmd;
		vec_x <= w.x; vec_y <= w.y; vec_z <= w.z;
		roll_angle <= w.roll; pitch_angle <= w.pitch; yaw_angle <= w.yaw;
		rotated_q.push_back(known ? r : rotate_vector(w));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stimulus: directed table, then random words with a quiet stretch and a drain pause.
	initial begin
		dir_row_t dir[$];
		rot_result_t none;
		int one;
		one = 32'sh0001_0000;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = 1'b0;
		vec_x = '0; vec_y = '0; vec_z = '0;
		roll_angle = '0; pitch_angle = '0; yaw_angle = '0;
		calm = 1'b0;
		drain_done = 1'b0;
		none = '{0, 0, 0};
		dir.push_back(row(mk(BodyToGround, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0));
		dir.push_back(row(mk(BodyToGround, one, 2 * one, 3 * one, 0, 0, 0)));
		dir.push_back(row(mk(GroundToBody, one, 2 * one, 3 * one, 0, 0, 0)));
		dir.push_back(row(mk(BodyToGround, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 16'h2000, 16'h2000, 16'h2000)));
		dir.push_back(row(mk(GroundToBody, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 16'h2000, 16'hE000, 16'h6000)));
		dir.push_back(row(mk(BodyToGround, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
			16'hFFFF, 16'hFFFF, 16'hFFFF)));
		dir.push_back(row(mk(GroundToBody, one, -one, one, 16'h4000, 16'h8000, 16'hC000)));
		dir.push_back(row(mk(BodyToGround, one, -one, one, 16'h4001, 16'h7FFF, 16'hBFFF)));
		dir.push_back(row(mk(BodyToGround, -one, one, 5 * one, 16'h8000, 16'h4000, 16'h0001)));
		dir.push_back(row(mk(GroundToBody, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678,
			16'h5555, 16'hAAAA, 16'h1234)));
		dir.push_back(row(mk(BodyToGround, -1, 1, -1, 16'hC000, 16'hC001, 16'h3FFF)));
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i]) send_word(dir[i].w, dir[i].known, dir[i].r);
		for (int n = 0; n < RandWords; n++) begin
			calm = (n >= 300 && n < 500);
			if (n == 1000) begin
				// Let the pipeline empty completely before going on.
				in_valid <= 1'b0;
				while (rotated_q.size() != 0) @(posedge clk);
				repeat (Latency) @(posedge clk);
			end
			send_word(rand_word(), 1'b0, none);
		end
		in_valid <= 1'b0;
		calm = 1'b0;
		while (rotated_q.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
		drain_done = 1'b1;
	end

	// Receiver stalls.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 22);
		end
	end

	// Compare each accepted word with the oldest prediction.
	always @(posedge clk) begin
		rot_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (rotated_q.size() == 0) begin
				$display("%0t: unexpected word x=%0d y=%0d z=%0d", $time, out_x, out_y, out_z);
				errors++;
			end else begin
				e = rotated_q.pop_front();
				if (out_x !== e.x) begin
					$display("%0t: out_x expected %0d actual %0d", $time, e.x, out_x);
					errors++;
				end
				if (out_y !== e.y) begin
					$display("%0t: out_y expected %0d actual %0d", $time, e.y, out_y);
					errors++;
				end
				if (out_z !== e.z) begin
					$display("%0t: out_z expected %0d actual %0d", $time, e.z, out_z);
					errors++;
				end
			end
		end
	end

	// Final verdict.
	initial begin
		errors = 0;
		wait (drain_done);
		if (errors == 0 && rotated_q.size() == 0)
			$display("euler_frame_vector_rotation_core verification clean");
		else
			$display("euler_frame_vector_rotation_core verification failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#2ms;
		$display("euler_frame_vector_rotation_core verification failed");
		$finish;
	end

endmodule
